FILE: rtl/core/tlfq_pkg.sv
// Shared types, codes and helpers for the three-level feedback queue scheduler.
// No dependencies; used by every module under rtl/core.
package tlfq_pkg;

    localparam logic [7:0] PRIO_MAX = 8'd149;
    localparam logic [7:0] LVL1_LOW = 8'd100;
    localparam logic [7:0] LVL2_LOW = 8'd50;

    localparam logic [15:0] THRESH_RST = 16'd1500;
    localparam logic [7:0]  BOOST_RST  = 8'd10;

    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_ONE  = 2'd1;
    localparam logic [1:0] LVL_TWO  = 2'd2;
    localparam logic [1:0] LVL_THR  = 2'd3;

    // request kinds
    localparam logic [1:0] REQ_ENQ   = 2'd0;
    localparam logic [1:0] REQ_DISP  = 2'd1;
    localparam logic [1:0] REQ_AGE   = 2'd2;
    localparam logic [1:0] REQ_CHECK = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    // configuration register indexes
    localparam logic CFG_THRESH = 1'b0;
    localparam logic CFG_BOOST  = 1'b1;

    // one ready-thread slot
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [31:0] wait_acc;
        logic [31:0] wait_start;
        logic [31:0] stamp;
    } slot_rec_t;

    // ordering key seen by the comparator
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [31:0] age;
    } order_key_t;

    function automatic logic [1:0] level_of(input logic [7:0] p);
        if (p >= LVL1_LOW) begin
            return LVL_ONE;
        end else if (p >= LVL2_LOW) begin
            return LVL_TWO;
        end
        return LVL_THR;
    endfunction

endpackage

FILE: rtl/core/tlfq_store.sv
// Slot record memory: one write port, one registered read port.
// Depends on tlfq_pkg for the record type.
module tlfq_store #(
    parameter int ENTRIES = 32
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(ENTRIES)-1:0]     wr_addr,
    input  tlfq_pkg::slot_rec_t            wr_data,
    input  logic [$clog2(ENTRIES)-1:0]     rd_addr,
    output tlfq_pkg::slot_rec_t            rd_data
);

    tlfq_pkg::slot_rec_t mem [ENTRIES];
    tlfq_pkg::slot_rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/tlfq_cmp.sv
// Shared service-order comparator: is the candidate ahead of the current best.
// Depends on tlfq_pkg for keys and the level helper.
module tlfq_cmp (
    input  logic                 best_vld,
    input  tlfq_pkg::order_key_t cand,
    input  tlfq_pkg::order_key_t best,
    output logic                 better
);

    logic [1:0] lc;
    logic [1:0] lb;
    logic       ahead;

    always_comb begin
        lc = tlfq_pkg::level_of(cand.prio);
        lb = tlfq_pkg::level_of(best.prio);
        if (lc != lb) begin
            ahead = (lc < lb);
        end else if (lc == tlfq_pkg::LVL_ONE && cand.burst != best.burst) begin
            ahead = (cand.burst < best.burst);
        end else if (lc == tlfq_pkg::LVL_TWO && cand.prio != best.prio) begin
            ahead = (cand.prio > best.prio);
        end else begin
            ahead = (cand.age > best.age);
        end
        better = !best_vld || ahead;
    end

endmodule

FILE: rtl/core/three_level_feedback_queue_scheduler.sv
// Three-level feedback ready scheduler; a sequencer scans the slot memory one slot
// a cycle through one shared comparator. Enqueue searches for the lowest free slot,
// and an out-of-range priority is dropped without a search; dispatch and check run one
// scan; aging runs one scan per aged slot and a final scan that finds no slot left.
// Next request taken the cycle after the result is loaded; an untaken result holds it.
// Reset (aresetn low, synchronous) clears valid bits, stamp counter, state; presets thr, boost.
// Depends on tlfq_pkg, tlfq_store, tlfq_cmp.
module three_level_feedback_queue_scheduler #(
    parameter int ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // thread_id[7:0], priority_req[15:8], burst[31:16], now[63:32]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], out_thread_id[9:2], out_level[11:10],
                                   // preempt[12], zero[15:13]
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);
    localparam logic [CW-1:0] DEPTH = CW'(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_ENQ, S_SCAN_INIT, S_SCAN, S_SCAN_END,
        S_ELAP, S_SUM, S_BOOST, S_RESP
    } state_t;

    state_t state_reg;

    logic [1:0]  req_reg;
    logic [7:0]  tid_reg;
    logic [7:0]  prio_reg;
    logic [15:0] burst_reg;
    logic [31:0] now_reg;
    logic [15:0] thr_reg;
    logic [7:0]  boost_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] done_reg;
    logic [31:0]        next_stamp_reg;

    logic [CW-1:0] issue_reg;
    logic          p1_vld_reg;
    logic [IW-1:0] p1_idx_reg;
    logic          p2_vld_reg;
    logic [IW-1:0] p2_idx_reg;
    tlfq_pkg::slot_rec_t p2_rec_reg;
    logic [31:0]   p2_age_reg;

    logic          best_vld_reg;
    logic [IW-1:0] best_idx_reg;
    tlfq_pkg::slot_rec_t best_rec_reg;
    logic [31:0]   best_age_reg;

    logic [31:0] elap_reg;
    logic [31:0] w_reg;

    logic [1:0] res_status_reg;
    logic [7:0] res_id_reg;
    logic [1:0] res_lvl_reg;
    logic       res_pre_reg;
    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    // memory ports
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    tlfq_pkg::slot_rec_t mem_wdata;
    tlfq_pkg::slot_rec_t mem_rdata;

    tlfq_store #(.ENTRIES(ENTRIES)) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (issue_reg[IW-1:0]),
        .rd_data (mem_rdata)
    );

    // shared comparator
    tlfq_pkg::order_key_t cand_key;
    tlfq_pkg::order_key_t best_key;
    logic                 better;

    assign cand_key = '{prio: p2_rec_reg.prio, burst: p2_rec_reg.burst, age: p2_age_reg};
    assign best_key = '{prio: best_rec_reg.prio, burst: best_rec_reg.burst, age: best_age_reg};

    tlfq_cmp u_cmp (
        .best_vld (best_vld_reg),
        .cand     (cand_key),
        .best     (best_key),
        .better   (better)
    );

    // candidate qualification at the read-data stage
    logic p1_ok;
    assign p1_ok = p1_vld_reg && valid_reg[p1_idx_reg]
                   && !(req_reg == tlfq_pkg::REQ_AGE && done_reg[p1_idx_reg]);

    // aging boost arithmetic
    logic [8:0]  np_sum;
    logic [7:0]  np;
    logic        hit;
    logic [1:0]  old_lvl;
    logic [1:0]  new_lvl;
    logic        restamp;
    logic [32:0] wsum;

    always_comb begin
        wsum    = {1'b0, best_rec_reg.wait_acc} + {1'b0, elap_reg};
        hit     = (w_reg >= {16'd0, thr_reg});
        np_sum  = {1'b0, best_rec_reg.prio} + {1'b0, boost_reg};
        np      = (np_sum > {1'b0, tlfq_pkg::PRIO_MAX}) ? tlfq_pkg::PRIO_MAX : np_sum[7:0];
        old_lvl = tlfq_pkg::level_of(best_rec_reg.prio);
        new_lvl = tlfq_pkg::level_of(np);
        restamp = hit && (new_lvl != old_lvl || new_lvl == tlfq_pkg::LVL_TWO);
    end

    // memory write selection
    logic enq_hit;
    assign enq_hit = (state_reg == S_ENQ) && !valid_reg[issue_reg[IW-1:0]];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = issue_reg[IW-1:0];
        mem_wdata = '{id: tid_reg, prio: prio_reg, burst: burst_reg, wait_acc: 32'd0,
                      wait_start: now_reg, stamp: next_stamp_reg};
        if (enq_hit) begin
            mem_we = 1'b1;
        end else if (state_reg == S_BOOST) begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_reg;
            mem_wdata = best_rec_reg;
            mem_wdata.prio       = hit ? np : best_rec_reg.prio;
            mem_wdata.wait_acc   = hit ? (w_reg - {16'd0, thr_reg}) : w_reg;
            mem_wdata.wait_start = now_reg;
            mem_wdata.stamp      = restamp ? next_stamp_reg : best_rec_reg.stamp;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // sequencer, state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            thr_reg        <= tlfq_pkg::THRESH_RST;
            boost_reg      <= tlfq_pkg::BOOST_RST;
            valid_reg      <= '0;
            done_reg       <= '0;
            next_stamp_reg <= 32'd0;
            issue_reg      <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            best_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tlfq_pkg::CFG_THRESH: thr_reg <= cfg_wdata;
                    tlfq_pkg::CFG_BOOST:  boost_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // result taken; S_RESP handles its own load
            if (m_tready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        req_reg        <= s_tuser;
                        tid_reg        <= s_tdata[7:0];
                        prio_reg       <= s_tdata[15:8];
                        burst_reg      <= s_tdata[31:16];
                        now_reg        <= s_tdata[63:32];
                        issue_reg      <= '0;
                        done_reg       <= '0;
                        res_id_reg     <= 8'd0;
                        res_lvl_reg    <= tlfq_pkg::LVL_NONE;
                        res_pre_reg    <= 1'b0;
                        if (s_tuser == tlfq_pkg::REQ_ENQ) begin
                            if (s_tdata[15:8] > tlfq_pkg::PRIO_MAX) begin
                                res_status_reg <= tlfq_pkg::ST_DROP;
                                state_reg      <= S_RESP;
                            end else begin
                                res_status_reg <= tlfq_pkg::ST_OK;
                                state_reg      <= S_ENQ;
                            end
                        end else begin
                            res_status_reg <= tlfq_pkg::ST_OK;
                            state_reg      <= S_SCAN_INIT;
                        end
                    end
                end

                // free-slot search, lowest index first
                S_ENQ: begin
                    if (enq_hit) begin
                        valid_reg[issue_reg[IW-1:0]] <= 1'b1;
                        next_stamp_reg <= next_stamp_reg + 32'd1;
                        state_reg      <= S_RESP;
                    end else if (issue_reg == LAST) begin
                        res_status_reg <= tlfq_pkg::ST_DROP;
                        state_reg      <= S_RESP;
                    end else begin
                        issue_reg <= issue_reg + CW'(1);
                    end
                end

                S_SCAN_INIT: begin
                    issue_reg    <= '0;
                    p1_vld_reg   <= 1'b0;
                    p2_vld_reg   <= 1'b0;
                    best_vld_reg <= 1'b0;
                    state_reg    <= S_SCAN;
                end

                // read, age, compare pipeline over all slots
                S_SCAN: begin
                    p1_vld_reg <= (issue_reg != DEPTH);
                    p1_idx_reg <= issue_reg[IW-1:0];
                    if (issue_reg != DEPTH) begin
                        issue_reg <= issue_reg + CW'(1);
                    end
                    p2_vld_reg <= p1_ok;
                    p2_idx_reg <= p1_idx_reg;
                    p2_rec_reg <= mem_rdata;
                    p2_age_reg <= next_stamp_reg - mem_rdata.stamp;
                    if (p2_vld_reg && better) begin
                        best_vld_reg <= 1'b1;
                        best_idx_reg <= p2_idx_reg;
                        best_rec_reg <= p2_rec_reg;
                        best_age_reg <= p2_age_reg;
                    end
                    if (issue_reg == DEPTH && !p1_vld_reg && !p2_vld_reg) begin
                        state_reg <= S_SCAN_END;
                    end
                end

                S_SCAN_END: begin
                    case (req_reg)
                        tlfq_pkg::REQ_DISP: begin
                            state_reg <= S_RESP;
                            if (best_vld_reg) begin
                                valid_reg[best_idx_reg] <= 1'b0;
                                res_id_reg  <= best_rec_reg.id;
                                res_lvl_reg <= tlfq_pkg::level_of(best_rec_reg.prio);
                            end else begin
                                res_status_reg <= tlfq_pkg::ST_EMPTY;
                            end
                        end
                        tlfq_pkg::REQ_AGE: begin
                            if (best_vld_reg) begin
                                state_reg <= S_ELAP;
                            end else begin
                                state_reg <= S_RESP;
                            end
                        end
                        default: begin
                            state_reg <= S_RESP;
                            if (prio_reg < tlfq_pkg::LVL2_LOW) begin
                                res_pre_reg <= |valid_reg;
                            end else if (prio_reg < tlfq_pkg::LVL1_LOW) begin
                                res_pre_reg <= best_vld_reg && tlfq_pkg::level_of(
                                    best_rec_reg.prio) == tlfq_pkg::LVL_ONE;
                            end else if (prio_reg <= tlfq_pkg::PRIO_MAX) begin
                                res_pre_reg <= best_vld_reg && tlfq_pkg::level_of(
                                    best_rec_reg.prio) == tlfq_pkg::LVL_ONE
                                    && best_rec_reg.burst < burst_reg;
                            end
                        end
                    endcase
                end

                // aging of the selected slot
                S_ELAP: begin
                    elap_reg  <= now_reg - best_rec_reg.wait_start;
                    state_reg <= S_SUM;
                end

                S_SUM: begin
                    w_reg     <= wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
                    state_reg <= S_BOOST;
                end

                S_BOOST: begin
                    done_reg[best_idx_reg] <= 1'b1;
                    if (restamp) begin
                        next_stamp_reg <= next_stamp_reg + 32'd1;
                    end
                    state_reg <= S_SCAN_INIT;
                end

                S_RESP: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'd0, res_pre_reg, res_lvl_reg, res_id_reg,
                                        res_status_reg};
                        state_reg   <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // stamp counter moves only on a stored enqueue or a boost write
    a_stamp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_ENQ && state_reg != S_BOOST) |=>
            next_stamp_reg == $past(next_stamp_reg))
        else $error("stamp counter changed outside enqueue or boost");

    // a level is reported only with an ok status
    a_level_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[11:10] != tlfq_pkg::LVL_NONE) |->
            m_data_reg[1:0] == tlfq_pkg::ST_OK)
        else $error("level reported with non-ok status");

    // preemption is never flagged with a failing status
    a_pre_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[12]) |->
            (m_data_reg[1:0] == tlfq_pkg::ST_OK && m_data_reg[11:10] == tlfq_pkg::LVL_NONE))
        else $error("preempt flag with dispatch or error data");

    // valid bits change only on an enqueue store or a dispatch
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_ENQ && state_reg != S_SCAN_END) |=> $stable(valid_reg))
        else $error("valid bits changed outside enqueue or dispatch");

endmodule
